FILE: rtl/pitl_pkg.sv
// shared types and constants for the point-in-tetrahedron locate unit
package pitl_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ELEM_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LANES        = 4;
    localparam int ROW_ADDR_W   = ELEM_W + 2;
    localparam int TABLE_ROWS   = MAX_ELEMENTS * LANES;

    localparam int COEF_W  = 32;
    localparam int COUNT_W = 11;
    localparam int TOL_W   = 17;
    localparam int FOUND_W = 10;
    localparam int N_W     = (ELEM_W + 1 > COUNT_W) ? ELEM_W + 1 : COUNT_W;
    localparam int ISSUE_W = N_W + 2;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int BIAS_W  = COEF_W + 2;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'(LANES - 1);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOCATE = 1'b1;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_TOL   = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

    typedef struct packed {
        logic                      func;
        logic [9:0]                element_index;
        logic [3:0]                coefficient_index;
        logic signed [COEF_W-1:0]  coefficient_value;
        logic signed [COEF_W-1:0]  pos_x;
        logic signed [COEF_W-1:0]  pos_y;
        logic signed [COEF_W-1:0]  pos_z;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [FOUND_W-1:0] found_element;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] element_count;
        logic [TOL_W-1:0]   inside_tolerance;
    } cfg_t;

    typedef logic [LANES-1:0][COEF_W-1:0] coef_row_t;

    typedef struct packed {
        logic                  valid;
        logic [ROW_ADDR_W-1:0] addr;
    } row_tag_t;

    typedef struct packed {
        logic                  active;
        logic                  ok_valid;
        logic                  ok;
        logic [ROW_ADDR_W-1:0] addr;
    } eval_stat_t;

endpackage

FILE: rtl/point_in_tet_locate_unit.sv
// point-in-tetrahedron locate unit: table writes and scanning locate requests
// write request: no result; busy stays low; one request at a time
// locate request: one matrix row per cycle, four rows per element; the result
// is taken once every issued row has drained, the scan stopping issue after the
// element that hits; the strobe lasts one cycle, busy drops with it
// reset clears control and configuration; the table is undefined until written
module point_in_tet_locate_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pitl_pkg::PADDR_W-1:0]  paddr,
    input  logic [pitl_pkg::PDATA_W-1:0]  pwdata,
    output logic [pitl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          start,
    input  pitl_pkg::req_t                req,
    output logic                          busy,
    output logic                          done,
    output pitl_pkg::rsp_t                rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                            state_reg, state_next;
    pitl_pkg::cfg_t                    cfg;
    pitl_pkg::coef_row_t               rd_data;
    pitl_pkg::row_tag_t                rd_tag_reg;
    pitl_pkg::eval_stat_t              stat;
    logic [pitl_pkg::ISSUE_W-1:0]      issue_reg, total_reg;
    logic [pitl_pkg::N_W-1:0]          n_clamp;
    logic signed [pitl_pkg::COEF_W-1:0] px_reg, py_reg, pz_reg;
    logic                              hit_reg, elem_ok_reg;
    logic [pitl_pkg::ELEM_W-1:0]       hit_elem_reg;
    logic                              done_reg;
    pitl_pkg::rsp_t                    rsp_reg;
    logic                              accept, mem_we, rd_en, issue_more, finish;
    logic [1:0]                        ret_row;

    pitl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;
    assign mem_we = accept & (req.func == pitl_pkg::FUNC_WRITE)
                  & (32'(req.element_index) < 32'(pitl_pkg::MAX_ELEMENTS));

    assign issue_more = (issue_reg != total_reg) & ~hit_reg;
    assign rd_en      = (state_reg == ST_SCAN) & issue_more;
    assign finish     = (state_reg == ST_SCAN) & ~issue_more & ~rd_tag_reg.valid
                      & ~stat.active;

    assign n_clamp = (32'(cfg.element_count) > 32'(pitl_pkg::MAX_ELEMENTS))
                   ? pitl_pkg::N_W'(pitl_pkg::MAX_ELEMENTS)
                   : pitl_pkg::N_W'(cfg.element_count);

    pitl_coef_store u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (pitl_pkg::ROW_ADDR_W'({req.element_index, req.coefficient_index[3:2]})),
        .wr_lane (req.coefficient_index[1:0]),
        .wr_data (req.coefficient_value),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[pitl_pkg::ROW_ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    pitl_row_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_tag (rd_tag_reg),
        .coef   (rd_data),
        .pos_x  (px_reg),
        .pos_y  (py_reg),
        .pos_z  (pz_reg),
        .tol    (cfg.inside_tolerance),
        .stat   (stat)
    );

    assign ret_row = stat.addr[1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.func == pitl_pkg::FUNC_LOCATE)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_reg        <= '0;
            total_reg        <= '0;
            hit_reg          <= 1'b0;
            elem_ok_reg      <= 1'b0;
            rd_tag_reg.valid <= 1'b0;
            rd_tag_reg.addr  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_tag_reg.valid <= rd_en;
            rd_tag_reg.addr  <= issue_reg[pitl_pkg::ROW_ADDR_W-1:0];
            done_reg         <= finish;
            if (accept && req.func == pitl_pkg::FUNC_LOCATE)
            begin
                issue_reg <= '0;
                total_reg <= {n_clamp, 2'b00};
                hit_reg   <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    issue_reg <= issue_reg + pitl_pkg::ISSUE_W'(1);
                end
                if (stat.ok_valid && !hit_reg)
                begin
                    if (ret_row == pitl_pkg::ROW_FIRST)
                    begin
                        elem_ok_reg <= stat.ok;
                    end
                    else
                    begin
                        elem_ok_reg <= elem_ok_reg & stat.ok;
                    end
                    if (ret_row == pitl_pkg::ROW_LAST && elem_ok_reg && stat.ok)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= req.pos_x;
            py_reg <= req.pos_y;
            pz_reg <= req.pos_z;
        end
        if (stat.ok_valid && !hit_reg)
        begin
            hit_elem_reg <= stat.addr[pitl_pkg::ROW_ADDR_W-1:2];
        end
        if (finish)
        begin
            rsp_reg.found         <= hit_reg;
            rsp_reg.found_element <= hit_reg ? pitl_pkg::FOUND_W'(hit_elem_reg) : '0;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SCAN))
        else $error("result strobe without a preceding scan");

    a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ST_SCAN) && !mem_we)
        else $error("table read outside a scan");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= total_reg))
        else $error("row issue passed the scan length");

    a_hit_from_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_reg) |-> $past(stat.ok_valid && stat.addr[1:0] == pitl_pkg::ROW_LAST))
        else $error("hit flagged without a last-row result");

endmodule

FILE: rtl/pitl_cfg_regs.sv
// configuration registers behind the apb-style port
module pitl_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pitl_pkg::PADDR_W-1:0]  paddr,
    input  logic [pitl_pkg::PDATA_W-1:0]  pwdata,
    output logic [pitl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output pitl_pkg::cfg_t                cfg
);

    logic [pitl_pkg::COUNT_W-1:0] count_reg;
    logic [pitl_pkg::TOL_W-1:0]   tol_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tol_reg   <= pitl_pkg::TOL_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                pitl_pkg::REG_COUNT: count_reg <= pwdata[pitl_pkg::COUNT_W-1:0];
                pitl_pkg::REG_TOL:   tol_reg   <= pwdata[pitl_pkg::TOL_W-1:0];
                default:             count_reg <= count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pitl_pkg::REG_COUNT: prdata = pitl_pkg::PDATA_W'(count_reg);
            pitl_pkg::REG_TOL:   prdata = pitl_pkg::PDATA_W'(tol_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.element_count    = count_reg;
    assign cfg.inside_tolerance = tol_reg;

endmodule

FILE: rtl/pitl_coef_store.sv
// coefficient table, one matrix row of four lanes per word, registered read
module pitl_coef_store (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [pitl_pkg::ROW_ADDR_W-1:0] wr_addr,
    input  logic [1:0]                      wr_lane,
    input  logic [pitl_pkg::COEF_W-1:0]     wr_data,
    input  logic                            rd_en,
    input  logic [pitl_pkg::ROW_ADDR_W-1:0] rd_addr,
    output pitl_pkg::coef_row_t             rd_data
);

    pitl_pkg::coef_row_t mem [pitl_pkg::TABLE_ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/pitl_row_eval.sv
// three-stage weight pipeline: products, pair sums, sign test against tolerance
module pitl_row_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pitl_pkg::row_tag_t                  rd_tag,
    input  pitl_pkg::coef_row_t                 coef,
    input  logic signed [pitl_pkg::COEF_W-1:0]  pos_x,
    input  logic signed [pitl_pkg::COEF_W-1:0]  pos_y,
    input  logic signed [pitl_pkg::COEF_W-1:0]  pos_z,
    input  logic [pitl_pkg::TOL_W-1:0]          tol,
    output pitl_pkg::eval_stat_t                stat
);

    localparam int PW = pitl_pkg::PROD_W;
    localparam int AW = pitl_pkg::ACC_W;
    localparam int BW = pitl_pkg::BIAS_W;
    localparam int CW = pitl_pkg::COEF_W;

    logic                            v2_reg, v3_reg, v4_reg;
    logic [pitl_pkg::ROW_ADDR_W-1:0] a2_reg, a3_reg, a4_reg;
    logic signed [PW-1:0]            p0_reg, p1_reg, p2_reg;
    logic [BW+15:0]                  p3_reg;
    logic [BW-1:0]                   bias;
    logic [AW-1:0]                   s01_reg, s23_reg;
    logic [AW-1:0]                   total;
    logic                            ok_reg;

    // constant column plus tolerance, scaled by one in q16.16
    assign bias  = {{(BW-CW){coef[3][CW-1]}}, coef[3]}
                 + {{(BW-pitl_pkg::TOL_W){1'b0}}, tol};
    assign total = s01_reg + s23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= rd_tag.valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a2_reg  <= rd_tag.addr;
        p0_reg  <= $signed(coef[0]) * pos_x;
        p1_reg  <= $signed(coef[1]) * pos_y;
        p2_reg  <= $signed(coef[2]) * pos_z;
        p3_reg  <= {bias, 16'b0};
        a3_reg  <= a2_reg;
        s01_reg <= {{(AW-PW){p0_reg[PW-1]}}, p0_reg} + {{(AW-PW){p1_reg[PW-1]}}, p1_reg};
        s23_reg <= {{(AW-PW){p2_reg[PW-1]}}, p2_reg}
                 + {{(AW-BW-16){p3_reg[BW+15]}}, p3_reg};
        a4_reg  <= a3_reg;
        ok_reg  <= ~total[AW-1];
    end

    assign stat.active   = v2_reg | v3_reg | v4_reg;
    assign stat.ok_valid = v4_reg;
    assign stat.ok       = ok_reg;
    assign stat.addr     = a4_reg;

endmodule

FILE: test/point_in_tet_locate_unit_tb.sv
// testbench for the point-in-tetrahedron locate unit: directed and random requests against a predictor
module point_in_tet_locate_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pitl_pkg::*;

    localparam int     TABLE_WORDS  = MAX_ELEMENTS * 16;
    localparam int     LOADED_ELEMS = 20;
    localparam int     ONE          = 65536;
    localparam int     DRAIN_CYCLES = 16;
    localparam longint CYCLE_LIMIT  = 8_000_000;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start   = 1'b0;
    req_t               req     = '0;
    logic               busy;
    logic               done;
    rsp_t               rsp;

    logic [COEF_W-1:0]  coef_mem [TABLE_WORDS];
    logic [COUNT_W-1:0] cfg_count;
    logic [TOL_W-1:0]   cfg_tol;
    rsp_t               expected_locates [$];

    int tet_x [MAX_ELEMENTS];
    int tet_y [MAX_ELEMENTS];
    int tet_z [MAX_ELEMENTS];
    int tet_size [MAX_ELEMENTS];

    int     idle_pct     = 0;
    int     mismatches   = 0;
    int     n_requests   = 0;
    int     n_locates    = 0;
    int     n_hits       = 0;
    int     n_writes     = 0;
    int     n_reg_writes = 0;
    longint cycles       = 0;

    always #5ns clk = ~clk;

    point_in_tet_locate_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp)
    );

    function automatic rsp_t locate_point(input logic signed [COEF_W-1:0] px,
                                          input logic signed [COEF_W-1:0] py,
                                          input logic signed [COEF_W-1:0] pz);
        logic signed [71:0] pt [4];
        logic signed [71:0] weight;
        logic signed [71:0] floor_w;
        int                 lim;
        bit                 contained;
        rsp_t               r;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        pt[3] = 72'sd65536;
        floor_w = 72'(cfg_tol);
        floor_w = -(floor_w <<< 16);
        lim = (cfg_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cfg_count);
        r = '0;
        for (int e = 0; e < lim && !r.found; e++)
        begin
            contained = 1'b1;
            for (int row = 0; row < 4; row++)
            begin
                weight = '0;
                for (int col = 0; col < 4; col++)
                    weight = weight + $signed(coef_mem[e * 16 + row * 4 + col]) * pt[col];
                if (weight < floor_w)
                    contained = 1'b0;
            end
            if (contained)
            begin
                r.found = 1'b1;
                r.found_element = FOUND_W'(e);
            end
        end
        return r;
    endfunction

    function automatic req_t coef_item(input int e, input int k, input logic [COEF_W-1:0] v);
        req_t it;
        it.func              = FUNC_WRITE;
        it.element_index     = 10'(e);
        it.coefficient_index = 4'(k);
        it.coefficient_value = v;
        it.pos_x             = $urandom;
        it.pos_y             = $urandom;
        it.pos_z             = $urandom;
        return it;
    endfunction

    function automatic req_t locate_item(input logic [COEF_W-1:0] px,
                                         input logic [COEF_W-1:0] py,
                                         input logic [COEF_W-1:0] pz);
        req_t it;
        it.func              = FUNC_LOCATE;
        it.element_index     = 10'($urandom_range(0, 1023));
        it.coefficient_index = 4'($urandom_range(0, 15));
        it.coefficient_value = $urandom;
        it.pos_x             = px;
        it.pos_y             = py;
        it.pos_z             = pz;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_result
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_locates.size() == 0)
                report_mismatch("result with no locate outstanding", 0, rsp.found);
            else
            begin
                want = expected_locates.pop_front();
                if (rsp.found !== want.found)
                    report_mismatch("found", want.found, rsp.found);
                if (rsp.found_element !== want.found_element)
                    report_mismatch("found_element", want.found_element, rsp.found_element);
            end
        end
    end

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_locates.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_request(input req_t item);
        rsp_t want;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            idle_cycles($urandom_range(1, 17));
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (item.func == FUNC_WRITE)
        begin
            coef_mem[{item.element_index, item.coefficient_index}] = item.coefficient_value;
            n_writes++;
        end
        else
        begin
            want = locate_point(item.pos_x, item.pos_y, item.pos_z);
            expected_locates = {expected_locates, want};
            n_locates++;
            if (want.found)
                n_hits++;
        end
        n_requests++;
        @(negedge clk);
    endtask

    task automatic reg_write(input logic sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == REG_COUNT)
            cfg_count = value[COUNT_W-1:0];
        else
            cfg_tol = value[TOL_W-1:0];
        n_reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic sel);
        logic [PDATA_W-1:0] want;
        want = (sel == REG_COUNT) ? PDATA_W'(cfg_count) : PDATA_W'(cfg_tol);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch("register readback", want, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int count, input int tol);
        wait_drained();
        reg_write(REG_COUNT, PDATA_W'(count));
        reg_write(REG_TOL, PDATA_W'(tol));
        reg_read(REG_COUNT);
        reg_read(REG_TOL);
    endtask

    // corner at (x0,y0,z0), legs of length size along each axis
    task automatic write_tet(input int e, input int x0, input int y0, input int z0,
                             input int size);
        int coef [16];
        tet_x[e]    = x0;
        tet_y[e]    = y0;
        tet_z[e]    = z0;
        tet_size[e] = size;
        coef = '{ONE, 0, 0, -x0,
                 0, ONE, 0, -y0,
                 0, 0, ONE, -z0,
                 -ONE, -ONE, -ONE, x0 + y0 + z0 + size};
        for (int k = 0; k < 16; k++)
            send_request(coef_item(e, k, coef[k]));
    endtask

    task automatic random_tet(input int e);
        int x0;
        int y0;
        int z0;
        int size;
        x0   = int'($urandom_range(0, 128 * ONE)) - 64 * ONE;
        y0   = int'($urandom_range(0, 128 * ONE)) - 64 * ONE;
        z0   = int'($urandom_range(0, 128 * ONE)) - 64 * ONE;
        size = int'($urandom_range(ONE / 2, 16 * ONE));
        write_tet(e, x0, y0, z0, size);
    endtask

    task automatic write_noise(input int e, input bit extreme);
        logic [COEF_W-1:0] v;
        tet_x[e]    = 0;
        tet_y[e]    = 0;
        tet_z[e]    = 0;
        tet_size[e] = ONE;
        for (int k = 0; k < 16; k++)
        begin
            if (extreme)
                v = (k % 2 == 1) ? 32'h7fff_ffff : 32'h8000_0000;
            else
                v = $urandom;
            send_request(coef_item(e, k, v));
        end
    endtask

    task automatic locate_near(input int e, input int mode);
        int a;
        int b;
        int c;
        int s;
        int px;
        int py;
        int pz;
        s = tet_size[e];
        case (mode)
            0:
            begin
                a  = int'($urandom_range(0, s));
                b  = int'($urandom_range(0, s - a));
                c  = int'($urandom_range(0, s - a - b));
                px = tet_x[e] + a;
                py = tet_y[e] + b;
                pz = tet_z[e] + c;
            end
            1:
            begin
                px = tet_x[e] - int'(cfg_tol) + int'($urandom_range(0, 6)) - 3;
                py = tet_y[e] + s / 4;
                pz = tet_z[e] + s / 4;
            end
            2:
            begin
                px = int'($urandom_range(0, 160 * ONE)) - 80 * ONE;
                py = int'($urandom_range(0, 160 * ONE)) - 80 * ONE;
                pz = int'($urandom_range(0, 160 * ONE)) - 80 * ONE;
            end
            default:
            begin
                px = $urandom;
                py = $urandom;
                pz = $urandom;
            end
        endcase
        send_request(locate_item(px, py, pz));
    endtask

    task automatic test_reset_state();
        reg_read(REG_COUNT);
        reg_read(REG_TOL);
        send_request(locate_item(0, 0, 0));
        send_request(locate_item($urandom, $urandom, $urandom));
        wait_drained();
    endtask

    task automatic test_table_load();
        idle_pct = 0;
        for (int e = 0; e < LOADED_ELEMS; e++)
        begin
            if (e == 0)
                write_tet(0, 0, 0, 0, ONE);
            else if (e == 3)
                write_noise(e, 1'b1);
            else if ($urandom_range(0, 9) == 0)
                write_noise(e, 1'b0);
            else
                random_tet(e);
        end
    endtask

    // element 0 is the unit tetrahedron at the origin
    task automatic test_face_tolerance();
        idle_pct = 10;
        set_config(1, 655);
        send_request(locate_item(ONE / 4, ONE / 4, ONE / 4));
        send_request(locate_item(0, 0, 0));
        send_request(locate_item(-655, ONE / 4, ONE / 4));
        send_request(locate_item(-656, ONE / 4, ONE / 4));
        send_request(locate_item(ONE / 4, ONE / 4, ONE / 2 + 655));
        send_request(locate_item(ONE / 4, ONE / 4, ONE / 2 + 656));
        send_request(locate_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(locate_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        set_config(1, 0);
        send_request(locate_item(0, ONE / 4, ONE / 4));
        send_request(locate_item(-1, ONE / 4, ONE / 4));
        set_config(1, 65536);
        send_request(locate_item(-ONE, 0, 0));
        send_request(locate_item(-ONE - 1, 0, 0));
    endtask

    // large counts only with points inside element 0, so the scan stops there
    task automatic test_scan_limits();
        set_config(0, 655);
        send_request(locate_item(ONE / 4, ONE / 4, ONE / 4));
        set_config(8, 655);
        send_request(locate_item(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_request(locate_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        set_config(1024, 0);
        send_request(locate_item(ONE / 4, ONE / 4, ONE / 4));
        locate_near(0, 0);
        set_config(2047, 131071);
        send_request(locate_item(ONE / 4, ONE / 4, ONE / 4));
        locate_near(0, 0);
    endtask

    task automatic test_random_traffic(input int count, input int tol, input int items,
                                       input int idle);
        int target;
        int lim;
        int pick;
        set_config(count, tol);
        idle_pct = idle;
        lim = (count > MAX_ELEMENTS) ? MAX_ELEMENTS : count;
        target = n_requests + items;
        while (n_requests < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                random_tet($urandom_range(0, lim - 1));
            else if (pick < 22)
                send_request(coef_item($urandom_range(0, MAX_ELEMENTS - 1),
                                       $urandom_range(0, 15), $urandom));
            else if (pick < 60)
                locate_near($urandom_range(0, lim - 1), 0);
            else if (pick < 75)
                locate_near($urandom_range(0, lim - 1), 1);
            else if (pick < 88)
                locate_near($urandom_range(0, lim - 1), 2);
            else
                locate_near($urandom_range(0, lim - 1), 3);
            if (idle > 0 && $urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        cfg_count = '0;
        cfg_tol   = TOL_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_table_load();
        test_face_tolerance();
        test_scan_limits();
        test_random_traffic(1, 655, 25, 15);
        test_random_traffic(16, 0, 25, 15);
        test_random_traffic(LOADED_ELEMS, 65536, 25, 15);
        test_random_traffic(7, int'($urandom_range(0, 65536)), 25, 15);
        test_random_traffic(LOADED_ELEMS, int'($urandom_range(0, 65536)), 25, 15);
        test_random_traffic(12, 131071, 25, 15);
        test_random_traffic(LOADED_ELEMS, 1, 20, 15);
        test_random_traffic(LOADED_ELEMS, 655, 40, 0);

        wait_drained();
        repeat (4 * MAX_ELEMENTS + 16) @(negedge clk);
        mismatches += expected_locates.size();
        $display("ran %0d requests: %0d locates (%0d predicted hits), %0d coefficient writes",
                 n_requests, n_locates, n_hits, n_writes);
        $display("%0d register writes, element counts 0..2047, tolerances 0..131071",
                 n_reg_writes);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: point_in_tet_locate_unit.f
rtl/pitl_pkg.sv
rtl/pitl_cfg_regs.sv
rtl/pitl_coef_store.sv
rtl/pitl_row_eval.sv
rtl/point_in_tet_locate_unit.sv
test/point_in_tet_locate_unit_tb.sv
